>>> hw/rtl/wfba_pkg.sv
// ============================================================================
// wfba_pkg : worst-fit block allocator shared definitions
// Sizes, item structs, status codes and sequencer states used by the
// allocator core and its sub-units.
// ============================================================================
package wfba_pkg;

   // Table geometry
   localparam int BLOCKS    = 16;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CNT_BITS  = $clog2(BLOCKS + 1);

   // Fixed field widths of the item ports
   localparam int CMD_W   = 1;
   localparam int INDEX_W = 4;
   localparam int SIZE_W  = 16;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

   // Result status codes
   typedef enum logic [STAT_W-1:0] {
      ST_LOADED    = 2'd0,
      ST_ALLOCATED = 2'd1,
      ST_NOFIT     = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // Input item
   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [INDEX_W-1:0] block_index;
      logic [SIZE_W-1:0]  size;
   } req_type;

   // Result item
   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] chosen_block;
      logic [SIZE_W-1:0]  space_left;
   } rsp_type;

   // Sequencer to scan unit
   typedef struct packed {
      logic                clear;
      logic                eval;
      logic [IDX_BITS-1:0] eval_idx;
   } scan_ctrl_type;

   // Scan unit to sequencer
   typedef struct packed {
      logic                 found;
      logic [IDX_BITS-1:0]  best;
      logic [SIZE_BITS-1:0] best_left;
   } scan_res_type;

endpackage

>>> hw/rtl/wfba_table.sv
// ============================================================================
// wfba_table : free space table
// One write port and one read port with registered read data. Entries hold
// no reset value; the user must load each before it is read; not enforced.
// ============================================================================
module wfba_table (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [wfba_pkg::IDX_BITS-1:0]    wr_addr,
   input  logic [wfba_pkg::SIZE_BITS-1:0]   wr_data,
   input  logic                             rd_en,
   input  logic [wfba_pkg::IDX_BITS-1:0]    rd_addr,
   output logic [wfba_pkg::SIZE_BITS-1:0]   rd_data
);
   import wfba_pkg::*;

   logic [SIZE_BITS-1:0] mem [BLOCKS];
   logic [SIZE_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/wfba_scan.sv
// ============================================================================
// wfba_scan : shared fit evaluation unit
// One subtract and one compare, used once per table entry. Keeps the block
// leaving the most space; ties stay with the earlier (lower) index.
// ============================================================================
module wfba_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  wfba_pkg::scan_ctrl_type         ctrl,
   input  logic [wfba_pkg::SIZE_BITS-1:0]  avail,
   input  logic [wfba_pkg::SIZE_BITS-1:0]  request,
   output wfba_pkg::scan_res_type          res
);
   import wfba_pkg::*;

   logic                 found_ff,     found_in;
   logic [IDX_BITS-1:0]  best_ff,      best_in;
   logic [SIZE_BITS-1:0] best_left_ff, best_left_in;
   logic [SIZE_BITS:0]   diff;
   logic                 fits;
   logic                 better;

   // Shared subtractor: borrow out means the entry is too small
   assign diff   = {1'b0, avail} - {1'b0, request};
   assign fits   = ~diff[SIZE_BITS];
   assign better = fits && (!found_ff || (diff[SIZE_BITS-1:0] > best_left_ff));

   // Best-so-far update
   always_comb begin
      found_in     = found_ff;
      best_in      = best_ff;
      best_left_in = best_left_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (ctrl.eval && better) begin
         found_in     = 1'b1;
         best_in      = ctrl.eval_idx;
         best_left_in = diff[SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_left_ff <= best_left_in;
   end

   assign res.found     = found_ff;
   assign res.best      = best_ff;
   assign res.best_left = best_left_ff;

endmodule

>>> hw/rtl/worst_fit_block_allocator_core.sv
// ============================================================================
// worst_fit_block_allocator_core : worst-fit block allocator
// Free space table with load and allocate commands, searched one block per
// cycle by a shared compare/subtract unit under a small sequencer.
// ============================================================================
// A load never raises busy and its result strobes in the cycle after start.
// An allocate over N = min(block_count, 16) blocks holds busy through S_SCAN
// (one table read per cycle into the shared fit unit, then evaluation of the
// last read) and S_FINISH (update); its result strobes as busy falls. N = 0
// answers like a load. Each result is on rsp_item for one cycle only with
// rsp_strobe high and cannot be held off, so the receiver must take it then.
// The user must write block_count through csr_we/csr_wdata only while no
// item is in flight; the core itself does not enforce this.
module worst_fit_block_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  wfba_pkg::req_type                 req_item,
   output logic                              rsp_strobe,
   output wfba_pkg::rsp_type                 rsp_item,
   input  logic                              csr_we,
   input  logic [wfba_pkg::COUNT_W-1:0]      csr_wdata
);
   import wfba_pkg::*;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    block_count_ff;
   logic [CNT_BITS-1:0]   limit_ff, limit_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [SIZE_BITS-1:0]  request_ff, request_in;
   logic                  ev_valid_ff, ev_valid_in;
   logic [IDX_BITS-1:0]   ev_idx_ff, ev_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic [CNT_BITS-1:0]   limit_new;
   logic                  issue;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [SIZE_BITS-1:0]  wr_data;
   logic [SIZE_BITS-1:0]  rd_data;
   scan_ctrl_type         scan_ctrl;
   scan_res_type          scan_res;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign issue  = (state_ff == S_SCAN) && (cnt_ff < limit_ff);

   // Search length, clamped to the table size
   assign limit_new = (32'(block_count_ff) > BLOCKS) ? CNT_BITS'(BLOCKS)
                                                    : CNT_BITS'(block_count_ff);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
      end else if (csr_we) begin
         block_count_ff <= csr_wdata;
      end
   end

   // Sequencer: next state, table writes and result
   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      cnt_in       = cnt_ff;
      request_in   = request_ff;
      ev_valid_in  = issue;
      ev_idx_in    = cnt_ff[IDX_BITS-1:0];
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = req_item.block_index[IDX_BITS-1:0];
      wr_data      = req_item.size[SIZE_BITS-1:0];
      scan_ctrl.clear    = 1'b0;
      scan_ctrl.eval     = ev_valid_ff;
      scan_ctrl.eval_idx = ev_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_LOAD) begin
                  // Out-of-range loads write nothing but still answer
                  wr_en = (32'(req_item.block_index) < BLOCKS);
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = ST_LOADED;
                  rsp_in.chosen_block = '0;
                  rsp_in.space_left   = '0;
               end else if (limit_new == '0) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = ST_NOFIT;
                  rsp_in.chosen_block = '0;
                  rsp_in.space_left   = '0;
               end else begin
                  limit_in        = limit_new;
                  cnt_in          = '0;
                  request_in      = req_item.size[SIZE_BITS-1:0];
                  scan_ctrl.clear = 1'b1;
                  state_in        = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Last read was issued the cycle before; it is evaluated now
            if (issue) begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            rsp_valid_in = 1'b1;
            if (scan_res.found) begin
               wr_en               = 1'b1;
               wr_addr             = scan_res.best;
               wr_data             = scan_res.best_left;
               rsp_in.status       = ST_ALLOCATED;
               rsp_in.chosen_block = INDEX_W'(scan_res.best);
               rsp_in.space_left   = SIZE_W'(scan_res.best_left);
            end else begin
               rsp_in.status       = ST_NOFIT;
               rsp_in.chosen_block = '0;
               rsp_in.space_left   = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         limit_ff     <= limit_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      request_ff <= request_in;
      ev_idx_ff  <= ev_idx_in;
      rsp_ff     <= rsp_in;
   end

   wfba_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (cnt_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   wfba_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (scan_ctrl),
      .avail   (rd_data),
      .request (request_ff),
      .res     (scan_res)
   );

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // Results only leave once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == S_IDLE))
      else $error("result strobed while sequencer busy");

   // A load answers in the very next cycle
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_item.command == CMD_LOAD)) |=>
         (rsp_strobe && (rsp_item.status == ST_LOADED)))
      else $error("load item not answered next cycle");

   // The update cycle always produces a result
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> rsp_strobe)
      else $error("allocate finished without a result");

   // Scan counter never passes the search length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (cnt_ff <= limit_ff))
      else $error("scan counter beyond search length");

endmodule

>>> test/worst_fit_block_allocator_core_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// worst_fit_block_allocator_core_checker : result checker for the allocator
// Watches the item, result and register ports of the allocator core, keeps
// its own copy of the free space table and block count, works out the
// result of every accepted item and compares the results as they come.
// ============================================================================
module worst_fit_block_allocator_core_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  wfba_pkg::req_type             req_item,
   input  logic                          rsp_strobe,
   input  wfba_pkg::rsp_type             rsp_item,
   input  logic                          csr_we,
   input  logic [wfba_pkg::COUNT_W-1:0]  csr_wdata,
   input  logic                          drain_check,
   output int unsigned                   fail_count
);
   import wfba_pkg::*;

   // Shadow state of the allocator
   logic [SIZE_BITS-1:0] space_table [BLOCKS];
   logic [COUNT_W-1:0]   search_count;
   rsp_type              awaited_results [$];
   logic                 drain_done;

   initial begin
      fail_count = 0;
      drain_done = 1'b0;
   end

   // One line per mismatch, and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Worst fit over the first min(count, BLOCKS) blocks, ties to the lowest
   // index; updates the shadow table as the core would
   function automatic rsp_type predict_allocation(input req_type r);
      rsp_type              res;
      int unsigned          lim;
      logic                 found;
      logic [INDEX_W-1:0]   best;
      logic [SIZE_BITS-1:0] best_left;
      logic [SIZE_BITS-1:0] left;
      res = '0;
      res.status = ST_LOADED;
      found = 1'b0;
      best = '0;
      best_left = '0;
      if (r.command == CMD_LOAD) begin
         if (int'(r.block_index) < BLOCKS)
            space_table[r.block_index] = r.size[SIZE_BITS-1:0];
         return res;
      end
      lim = (search_count > BLOCKS) ? BLOCKS : search_count;
      for (int j = 0; j < lim; j++) begin
         if (space_table[j] >= r.size[SIZE_BITS-1:0]) begin
            left = space_table[j] - r.size[SIZE_BITS-1:0];
            if (!found || left > best_left) begin
               found = 1'b1;
               best = j[INDEX_W-1:0];
               best_left = left;
            end
         end
      end
      if (!found) begin
         res.status = ST_NOFIT;
         return res;
      end
      space_table[best] = best_left;
      res.status = ST_ALLOCATED;
      res.chosen_block = best;
      res.space_left = best_left;
      return res;
   endfunction

   // Results first (they belong to earlier items), then register, then item
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         search_count = '0;
         awaited_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_item), 32'd0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
               if (rsp_item.chosen_block !== want.chosen_block)
                  report_mismatch("chosen_block", 32'(rsp_item.chosen_block),
                                  32'(want.chosen_block));
               if (rsp_item.space_left !== want.space_left)
                  report_mismatch("space_left", 32'(rsp_item.space_left),
                                  32'(want.space_left));
            end
         end
         if (csr_we)
            search_count = csr_wdata;
         if (start && !busy)
            awaited_results.push_back(predict_allocation(req_item));
      end
      // End of run: anything still awaited never came
      if (drain_check && !drain_done) begin
         drain_done = 1'b1;
         while (awaited_results.size() != 0) begin
            want = awaited_results.pop_front();
            report_mismatch("missing result", 32'd0, 32'(want));
         end
      end
   end

endmodule

>>> test/worst_fit_block_allocator_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// worst_fit_block_allocator_core_tb : testbench for the worst-fit allocator
// Loads the free space table, then runs directed and random load/allocate
// items over several block counts, with random gaps on the item side. The
// checker beside the core predicts and compares every result.
// ============================================================================
module worst_fit_block_allocator_core_tb;
   import wfba_pkg::*;

   localparam real         CLK_PERIOD  = 12.0;
   localparam int          RESET_CYCLES = 7;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int          PHASE_ITEMS = 75;
   localparam int          TAIL_CYCLES = 24;

   // Initial free sizes: extremes, a tie at 16'h8000, assorted bit patterns
   localparam logic [SIZE_W-1:0] INITIAL_SPACE [16] = '{
      16'h0000, 16'h0064, 16'h8000, 16'h8000, 16'h0005, 16'h1234, 16'h7FFF,
      16'h00FF, 16'h0001, 16'h4000, 16'h2000, 16'h0800, 16'h7000, 16'h0ABC,
      16'h5555, 16'hFFFF};

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_item;
   logic               rsp_strobe;
   rsp_type            rsp_item;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;
   logic               drain_check;
   int unsigned        fail_count;
   int unsigned        items_sent;
   int unsigned        results_seen;
   int unsigned        cycle_count;
   bit                 gaps_on;

   always #(CLK_PERIOD / 2) clock = ~clock;

   worst_fit_block_allocator_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   worst_fit_block_allocator_core_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .drain_check (drain_check),
      .fail_count  (fail_count)
   );

   // Result count and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_strobe)
         results_seen <= results_seen + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type make_item(input logic [CMD_W-1:0] cmd,
                                         input logic [INDEX_W-1:0] idx,
                                         input logic [SIZE_W-1:0] sz);
      req_type r;
      r.command = cmd;
      r.block_index = idx;
      r.size = sz;
      return r;
   endfunction

   // Present one item and hold it until taken; start stays high afterwards
   task automatic send_item(input req_type r);
      int n;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         n = $urandom_range(1, 17);
         repeat (n) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // Drop start and wait for every outstanding result
   task automatic wait_drained();
      start <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   task automatic write_block_count(input logic [COUNT_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Random item: mostly allocates with modest requests, loads to refill
   function automatic req_type random_item();
      logic [INDEX_W-1:0] idx;
      logic [SIZE_W-1:0]  sz;
      int unsigned        pick;
      idx = INDEX_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 30) begin
         if (pick < 50)
            sz = SIZE_W'($urandom);
         else if (pick < 75)
            sz = (pick[0]) ? 16'h4000 : 16'hFFFF;
         else
            sz = SIZE_W'($urandom_range(0, 255));
         return make_item(CMD_LOAD, idx, sz);
      end
      if (pick < 10)
         sz = '0;
      else if (pick < 60)
         sz = SIZE_W'($urandom_range(1, 4095));
      else if (pick < 85)
         sz = SIZE_W'($urandom_range(4096, 32767));
      else
         sz = SIZE_W'($urandom);
      return make_item(CMD_ALLOC, idx, sz);
   endfunction

   initial begin
      int phase_counts [7];
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      drain_check = 1'b0;
      items_sent = 0;
      results_seen = 0;
      cycle_count = 0;
      gaps_on = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty search: block count is still zero
      send_item(make_item(CMD_ALLOC, 4'hF, 16'h0000));
      send_item(make_item(CMD_ALLOC, 4'h0, 16'hFFFF));

      // Fill the whole table before any search can reach it
      for (int i = 0; i < 16; i++)
         send_item(make_item(CMD_LOAD, i[INDEX_W-1:0], INITIAL_SPACE[i]));

      write_block_count(5'd16);
      // Zero request, full-size request, tie at the top, then no fit
      send_item(make_item(CMD_ALLOC, 4'h0, 16'h0000));
      send_item(make_item(CMD_ALLOC, 4'h5, 16'hFFFF));
      send_item(make_item(CMD_ALLOC, 4'hA, 16'h8000));
      send_item(make_item(CMD_ALLOC, 4'hF, 16'hFFFF));

      // Count above the table size searches all blocks
      write_block_count(5'd31);
      send_item(make_item(CMD_ALLOC, 4'h3, 16'h0001));

      // Single block with zero free space still takes a zero request
      write_block_count(5'd1);
      send_item(make_item(CMD_ALLOC, 4'h9, 16'h0000));
      send_item(make_item(CMD_ALLOC, 4'h6, 16'h0001));

      // Random phases over several block counts, no gaps in the last one
      phase_counts = '{16, 1, 31, 0, 0, 17, 16};
      phase_counts[3] = $urandom_range(2, 15);
      for (int p = 0; p < 7; p++) begin
         write_block_count(phase_counts[p][COUNT_W-1:0]);
         gaps_on = (p != 6);
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_item(random_item());
      end

      // Drain, allow for stray results, then look for leftovers
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      drain_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/wfba_pkg.sv
hw/rtl/wfba_table.sv
hw/rtl/wfba_scan.sv
hw/rtl/worst_fit_block_allocator_core.sv
test/worst_fit_block_allocator_core_checker.sv
test/worst_fit_block_allocator_core_tb.sv
